// ===== rtl/bf3_pkg.sv =====
// Shared types, constants and helper functions of the 3x3 box filter.
`timescale 1ns / 1ps
`default_nettype none

package bf3_pkg;

   localparam int MAX_FRAME = 1024;

   localparam int PIX_W   = 16;
   localparam int FS_W    = 11;
   localparam int COL_W   = 18;
   localparam int SUM_W   = 20;
   localparam int CNT_W   = 4;
   localparam int RECIP_W = 21;
   localparam int FRAC_W  = 20;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int REM_W   = SUM_W + CNT_W;

   localparam logic [FS_W-1:0] FRAME_RESET = 11'd64;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PIX_RD,
      ST_DRN_L,
      ST_DRN_C,
      ST_DRN_R,
      ST_SUM,
      ST_ACC,
      ST_MUL,
      ST_FIX
   } state_type;

   function automatic logic [PIX_W-1:0] chan(pixel_type p, logic [1:0] sel);
      logic [PIX_W-1:0] v;
      case (sel)
         2'd0:    v = p.red;
         2'd1:    v = p.green;
         default: v = p.blue;
      endcase
      return v;
   endfunction

   // floor(2^FRAC_W / count) for the neighbourhood sizes that can occur.
   function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] v;
      case (cnt)
         4'd2:    v = 21'd524288;
         4'd3:    v = 21'd349525;
         4'd4:    v = 21'd262144;
         4'd6:    v = 21'd174762;
         4'd9:    v = 21'd116508;
         default: v = 21'd1048576;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bf3_if.sv =====
// Handshake channels of the box filter: pixel requests, results and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface bf3_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [bf3_pkg::PIX_W-1:0]  in_red;
   logic [bf3_pkg::PIX_W-1:0]  in_green;
   logic [bf3_pkg::PIX_W-1:0]  in_blue;
   modport source (output valid, opcode, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, opcode, in_red, in_green, in_blue, output ready);
endinterface

interface bf3_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bf3_pkg::PIX_W-1:0]  out_red;
   logic [bf3_pkg::PIX_W-1:0]  out_green;
   logic [bf3_pkg::PIX_W-1:0]  out_blue;
   logic                       frame_end;
   modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface bf3_csr_if;
   logic                       valid;
   logic                       ready;
   logic [bf3_pkg::FS_W-1:0]   frame_size;
   modport source (output valid, frame_size, input ready);
   modport sink   (input valid, frame_size, output ready);
endinterface

`default_nettype wire

// ===== rtl/bf3_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module bf3_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/box_filter_3x3_edge_clipped_unit.sv =====
// Streaming 3x3 box filter, edge clipped, on a square frame held in two line RAMs.
// A pixel word yields no result, one result, or two results at the last column; a drain
// word yields one result. Words that are ignored are accepted and dropped. A result
// passes from its last line RAM read through the shared sum, accumulate, multiply and
// correct states to the output register; correct waits while that register is full and not taken.
// Reset is synchronous; the line RAMs are not cleared and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_3x3_edge_clipped_unit #(
   parameter int MAX_FRAME = bf3_pkg::MAX_FRAME
) (
   input wire logic   clock,
   input wire logic   reset,
   bf3_csr_if.sink    csr_port,
   bf3_req_if.sink    req_port,
   bf3_rsp_if.source  rsp_port
);

   localparam int AW = $clog2(MAX_FRAME);
   localparam int NW = $clog2(MAX_FRAME + 1);
   localparam int RESET_N = (int'(bf3_pkg::FRAME_RESET) > MAX_FRAME) ?
                            MAX_FRAME : int'(bf3_pkg::FRAME_RESET);

   bf3_pkg::state_type state_ff, state_in;

   logic [NW-1:0] n_ff, n_in;
   logic [NW-1:0] row_ff, row_in;
   logic [AW-1:0] col_ff, col_in;
   logic [AW-1:0] drain_ff, drain_in;

   bf3_pkg::pixel_type wl_ff [3];
   bf3_pkg::pixel_type wl_in [3];
   bf3_pkg::pixel_type wc_ff [3];
   bf3_pkg::pixel_type wc_in [3];
   bf3_pkg::pixel_type nb_ff [3][3];
   bf3_pkg::pixel_type nb_in [3][3];
   bf3_pkg::pixel_type cur2_ff, cur2_in;

   logic [2:0] col_mask_ff, col_mask_in;
   logic [2:0] row_mask_ff, row_mask_in;
   logic       fe_ff, fe_in;
   logic       second_ff, second_in;

   logic [bf3_pkg::COL_W-1:0]  col_sum_ff [3][3];
   logic [bf3_pkg::COL_W-1:0]  col_sum_in [3][3];
   logic [bf3_pkg::SUM_W-1:0]  tot_ff [3];
   logic [bf3_pkg::SUM_W-1:0]  tot_in [3];
   logic [bf3_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [bf3_pkg::PROD_W-1:0] prod_ff [3];
   logic [bf3_pkg::PROD_W-1:0] prod_in [3];
   logic [bf3_pkg::PIX_W-1:0]  quot [3];

   logic               rsp_valid_ff, rsp_valid_in;
   bf3_pkg::pixel_type out_pix_ff, out_pix_in;
   logic               out_fe_ff, out_fe_in;

   logic [NW-1:0]      csr_n;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      drn_left;
   logic [AW-1:0]      drn_right;
   logic               last_col;
   logic               last_drain;
   bf3_pkg::pixel_type older_q;
   bf3_pkg::pixel_type newer_q;

   bf3_ram #(
      .WIDTH ($bits(bf3_pkg::pixel_type)),
      .DEPTH (MAX_FRAME)
   ) u_older_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (col_ff),
      .wr_data (newer_q),
      .rd_addr (rd_addr),
      .rd_data (older_q)
   );

   bf3_ram #(
      .WIDTH ($bits(bf3_pkg::pixel_type)),
      .DEPTH (MAX_FRAME)
   ) u_newer_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (col_ff),
      .wr_data (cur2_ff),
      .rd_addr (rd_addr),
      .rd_data (newer_q)
   );

   // Out-of-range frame sizes are clamped to 1 .. MAX_FRAME.
   always_comb begin
      if (csr_port.frame_size == '0) begin
         csr_n = NW'(1);
      end else if (int'(csr_port.frame_size) > MAX_FRAME) begin
         csr_n = NW'(MAX_FRAME);
      end else begin
         csr_n = NW'(csr_port.frame_size);
      end
   end

   assign last_col   = (NW'(col_ff) == n_ff - NW'(1));
   assign last_drain = (NW'(drain_ff) == n_ff - NW'(1));
   assign drn_left   = (drain_ff == '0) ? drain_ff : drain_ff - AW'(1);
   assign drn_right  = (NW'(drain_ff) + NW'(1) < n_ff) ? drain_ff + AW'(1) : drain_ff;

   // Arithmetic of the shared averaging sequence.
   always_comb begin
      logic [1:0]               ncols;
      logic [1:0]               nrows;
      logic [bf3_pkg::COL_W-1:0] acc_c;
      logic [bf3_pkg::SUM_W-1:0] acc_t;
      logic [bf3_pkg::SUM_W-1:0] q0;
      logic [bf3_pkg::REM_W-1:0] back;
      logic [bf3_pkg::REM_W-1:0] rem;
      for (int j = 0; j < 3; j++) begin
         for (int ch = 0; ch < 3; ch++) begin
            acc_c = '0;
            for (int r = 0; r < 3; r++) begin
               if (row_mask_ff[r]) begin
                  acc_c = acc_c + bf3_pkg::COL_W'(bf3_pkg::chan(nb_ff[j][r], 2'(ch)));
               end
            end
            col_sum_in[j][ch] = acc_c;
         end
      end
      for (int ch = 0; ch < 3; ch++) begin
         acc_t = '0;
         for (int j = 0; j < 3; j++) begin
            if (col_mask_ff[j]) begin
               acc_t = acc_t + bf3_pkg::SUM_W'(col_sum_ff[j][ch]);
            end
         end
         tot_in[ch] = acc_t;
      end
      ncols  = 2'($countones(col_mask_ff));
      nrows  = 2'($countones(row_mask_ff));
      cnt_in = {2'b00, ncols} * {2'b00, nrows};
      for (int ch = 0; ch < 3; ch++) begin
         prod_in[ch] = bf3_pkg::PROD_W'(tot_ff[ch]) *
                       bf3_pkg::PROD_W'(bf3_pkg::recip(cnt_ff));
      end
      // The reciprocal estimate is at most one short; one compare fixes it.
      for (int ch = 0; ch < 3; ch++) begin
         q0   = prod_ff[ch][bf3_pkg::FRAC_W +: bf3_pkg::SUM_W];
         back = bf3_pkg::REM_W'(q0) * bf3_pkg::REM_W'(cnt_ff);
         rem  = bf3_pkg::REM_W'(tot_ff[ch]) - back;
         if (rem >= bf3_pkg::REM_W'(cnt_ff)) begin
            quot[ch] = bf3_pkg::PIX_W'(q0 + bf3_pkg::SUM_W'(1));
         end else begin
            quot[ch] = bf3_pkg::PIX_W'(q0);
         end
      end
   end

   // Next state and outputs of the sequencer.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      drain_in     = drain_ff;
      wl_in        = wl_ff;
      wc_in        = wc_ff;
      nb_in        = nb_ff;
      cur2_in      = cur2_ff;
      col_mask_in  = col_mask_ff;
      row_mask_in  = row_mask_ff;
      fe_in        = fe_ff;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff;
      out_pix_in   = out_pix_ff;
      out_fe_in    = out_fe_ff;
      req_port.ready = 1'b0;
      rd_addr      = col_ff;
      wr_en        = 1'b0;

      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         bf3_pkg::ST_IDLE: begin
            req_port.ready = 1'b1;
            if (req_port.valid) begin
               if (req_port.opcode == bf3_pkg::OP_PIXEL) begin
                  if (row_ff < n_ff && NW'(col_ff) < n_ff) begin
                     cur2_in.red   = req_port.in_red;
                     cur2_in.green = req_port.in_green;
                     cur2_in.blue  = req_port.in_blue;
                     state_in      = bf3_pkg::ST_PIX_RD;
                  end
               end else if (row_ff >= n_ff && NW'(drain_ff) < n_ff) begin
                  rd_addr  = drn_left;
                  state_in = bf3_pkg::ST_DRN_L;
               end
            end
         end
         bf3_pkg::ST_PIX_RD: begin
            // Column c of the two line RAMs moves up one row.
            wr_en = 1'b1;
            for (int r = 0; r < 3; r++) begin
               nb_in[0][r] = wl_ff[r];
               nb_in[1][r] = wc_ff[r];
            end
            nb_in[2][0] = older_q;
            nb_in[2][1] = newer_q;
            nb_in[2][2] = cur2_ff;
            wl_in       = wc_ff;
            wc_in[0]    = older_q;
            wc_in[1]    = newer_q;
            wc_in[2]    = cur2_ff;
            col_mask_in = {2'b11, (col_ff >= AW'(2))};
            row_mask_in = {2'b11, (row_ff >= NW'(2))};
            fe_in       = 1'b0;
            second_in   = last_col;
            if (last_col) begin
               col_in = '0;
               row_in = row_ff + NW'(1);
            end else begin
               col_in = col_ff + AW'(1);
            end
            if (row_ff != '0 && col_ff != '0) begin
               state_in = bf3_pkg::ST_SUM;
            end else begin
               state_in = bf3_pkg::ST_IDLE;
            end
         end
         bf3_pkg::ST_DRN_L: begin
            nb_in[0][0] = older_q;
            nb_in[0][1] = newer_q;
            rd_addr     = drain_ff;
            state_in    = bf3_pkg::ST_DRN_C;
         end
         bf3_pkg::ST_DRN_C: begin
            nb_in[1][0] = older_q;
            nb_in[1][1] = newer_q;
            rd_addr     = drn_right;
            state_in    = bf3_pkg::ST_DRN_R;
         end
         bf3_pkg::ST_DRN_R: begin
            nb_in[2][0] = older_q;
            nb_in[2][1] = newer_q;
            col_mask_in = {(NW'(drain_ff) + NW'(1) < n_ff), 1'b1, (drain_ff != '0)};
            row_mask_in = {1'b0, 1'b1, (n_ff >= NW'(2))};
            fe_in       = last_drain;
            second_in   = 1'b0;
            if (last_drain) begin
               row_in   = '0;
               col_in   = '0;
               drain_in = '0;
            end else begin
               drain_in = drain_ff + AW'(1);
            end
            state_in = bf3_pkg::ST_SUM;
         end
         bf3_pkg::ST_SUM: begin
            state_in = bf3_pkg::ST_ACC;
         end
         bf3_pkg::ST_ACC: begin
            state_in = bf3_pkg::ST_MUL;
         end
         bf3_pkg::ST_MUL: begin
            state_in = bf3_pkg::ST_FIX;
         end
         bf3_pkg::ST_FIX: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in     = 1'b1;
               out_pix_in.red   = quot[0];
               out_pix_in.green = quot[1];
               out_pix_in.blue  = quot[2];
               out_fe_in        = fe_ff;
               if (second_ff) begin
                  // Right frame edge: the shifted window already holds the last two columns.
                  for (int r = 0; r < 3; r++) begin
                     nb_in[0][r] = wl_ff[r];
                     nb_in[1][r] = wc_ff[r];
                  end
                  col_mask_in = 3'b011;
                  second_in   = 1'b0;
                  state_in    = bf3_pkg::ST_SUM;
               end else begin
                  state_in = bf3_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = bf3_pkg::ST_IDLE;
         end
      endcase

      if (csr_port.valid) begin
         n_in     = csr_n;
         row_in   = '0;
         col_in   = '0;
         drain_in = '0;
      end
   end

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bf3_pkg::ST_IDLE;
         n_ff         <= NW'(RESET_N);
         row_ff       <= '0;
         col_ff       <= '0;
         drain_ff     <= '0;
         fe_ff        <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            wl_ff[r] <= '0;
            wc_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         drain_ff     <= drain_in;
         fe_ff        <= fe_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
         wl_ff        <= wl_in;
         wc_ff        <= wc_in;
      end
   end

   always_ff @(posedge clock) begin
      nb_ff       <= nb_in;
      cur2_ff     <= cur2_in;
      col_mask_ff <= col_mask_in;
      row_mask_ff <= row_mask_in;
      col_sum_ff  <= col_sum_in;
      tot_ff      <= tot_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      out_pix_ff  <= out_pix_in;
      out_fe_ff   <= out_fe_in;
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.out_red   = out_pix_ff.red;
   assign rsp_port.out_green = out_pix_ff.green;
   assign rsp_port.out_blue  = out_pix_ff.blue;
   assign rsp_port.frame_end = out_fe_ff;

endmodule

`default_nettype wire
